[sv/bnc_pkg.sv]
// ============================================================================
// bnc_pkg: shared types, constants and microprogram of the binomial unit
// Holds the field widths, the control word layout and the read-only
// microprogram that sequences the datapath.
// ============================================================================
package bnc_pkg;

    localparam int SIZE_W  = 6;
    localparam int COMB_W  = 63;
    localparam int STEP_W  = 4;

    typedef logic [STEP_W-1:0] step_t;

    // Datapath operations, one per control word.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_NUM,
        OP_INIT_DEN,
        OP_MUL_DEN,
        OP_INIT_DIV,
        OP_DIV_STEP,
        OP_SET_OVF,
        OP_PUBLISH
    } op_t;

    // Jump conditions; the jump goes to the target when the condition holds,
    // otherwise the step counter advances by one.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_SPECIAL,
        C_NUM_DONE,
        C_DEN_DONE,
        C_OVF,
        C_BITS_LEFT
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        op_t  op;
        logic req_taken;
    } bnc_ctrl_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic special;
        logic num_done;
        logic den_done;
        logic ovf;
        logic bits_left;
    } bnc_stat_t;

    localparam step_t STEP_IDLE      = 4'd0;
    localparam step_t STEP_CLASSIFY  = 4'd1;
    localparam step_t STEP_NUM_TEST  = 4'd2;
    localparam step_t STEP_NUM_MUL   = 4'd3;
    localparam step_t STEP_DEN_INIT  = 4'd4;
    localparam step_t STEP_DEN_TEST  = 4'd5;
    localparam step_t STEP_DEN_MUL   = 4'd6;
    localparam step_t STEP_DIV_INIT  = 4'd7;
    localparam step_t STEP_DIV_LOOP  = 4'd8;
    localparam step_t STEP_DIV_END   = 4'd9;
    localparam step_t STEP_OVF       = 4'd10;
    localparam step_t STEP_WAIT_OUT  = 4'd11;
    localparam step_t STEP_PUBLISH   = 4'd12;

    // The microprogram. A wait on a busy output slot is handled by the
    // sequencer itself at the wait step, not by a condition code.
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        begin
            w = '{op: OP_NONE, cond: C_NEVER, target: STEP_IDLE};
            unique case (s)
                STEP_IDLE:     w = '{op: OP_LOAD,     cond: C_NO_REQ,    target: STEP_IDLE};
                STEP_CLASSIFY: w = '{op: OP_NONE,     cond: C_SPECIAL,   target: STEP_WAIT_OUT};
                STEP_NUM_TEST: w = '{op: OP_NONE,     cond: C_NUM_DONE,  target: STEP_DEN_INIT};
                STEP_NUM_MUL:  w = '{op: OP_MUL_NUM,  cond: C_ALWAYS,    target: STEP_NUM_TEST};
                STEP_DEN_INIT: w = '{op: OP_INIT_DEN, cond: C_NEVER,     target: STEP_IDLE};
                STEP_DEN_TEST: w = '{op: OP_NONE,     cond: C_DEN_DONE,  target: STEP_DIV_INIT};
                STEP_DEN_MUL:  w = '{op: OP_MUL_DEN,  cond: C_ALWAYS,    target: STEP_DEN_TEST};
                STEP_DIV_INIT: w = '{op: OP_INIT_DIV, cond: C_OVF,       target: STEP_OVF};
                STEP_DIV_LOOP: w = '{op: OP_DIV_STEP, cond: C_BITS_LEFT, target: STEP_DIV_LOOP};
                STEP_DIV_END:  w = '{op: OP_NONE,     cond: C_ALWAYS,    target: STEP_WAIT_OUT};
                STEP_OVF:      w = '{op: OP_SET_OVF,  cond: C_NEVER,     target: STEP_IDLE};
                STEP_WAIT_OUT: w = '{op: OP_NONE,     cond: C_NEVER,     target: STEP_IDLE};
                STEP_PUBLISH:  w = '{op: OP_PUBLISH,  cond: C_ALWAYS,    target: STEP_IDLE};
                default:       w = '{op: OP_NONE,     cond: C_ALWAYS,    target: STEP_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

[sv/bnc_req_if.sv]
// ============================================================================
// bnc_req_if: request channel of the binomial unit
// Carries one set size and one subset size per request.
// ============================================================================
interface bnc_req_if;
    import bnc_pkg::*;

    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] set_size;
    logic [SIZE_W-1:0] subset_size;

    modport source (output valid, output set_size, output subset_size, input ready);
    modport sink   (input valid, input set_size, input subset_size, output ready);
endinterface

[sv/bnc_rsp_if.sv]
// ============================================================================
// bnc_rsp_if: result channel of the binomial unit
// Carries the coefficient and the overflow flag of one request.
// ============================================================================
interface bnc_rsp_if;
    import bnc_pkg::*;

    logic              valid;
    logic              ready;
    logic [COMB_W-1:0] combinations;
    logic              overflowed;

    modport source (output valid, output combinations, output overflowed, input ready);
    modport sink   (input valid, input combinations, input overflowed, output ready);
endinterface

[sv/bnc_datapath.sv]
// ============================================================================
// bnc_datapath: arithmetic datapath of the binomial unit
// One shared narrow multiplier for numerator and denominator products, and a
// restoring divider that retires one quotient bit per step.
// ============================================================================
module bnc_datapath #(
    parameter int VALUE_BITS = 63
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bnc_pkg::bnc_ctrl_t            ctrl,
    input  logic [bnc_pkg::SIZE_W-1:0]    set_size,
    input  logic [bnc_pkg::SIZE_W-1:0]    subset_size,
    output bnc_pkg::bnc_stat_t            stat,
    output logic [VALUE_BITS-1:0]         quotient,
    output logic                          overflow
);
    import bnc_pkg::*;

    localparam int BIT_W  = $clog2(VALUE_BITS);
    localparam int PROD_W = VALUE_BITS + SIZE_W;

    logic [SIZE_W-1:0]     m_reg, d_reg, cnt_reg;
    logic [VALUE_BITS-1:0] acc_reg, den_reg, rem_reg, quo_reg;
    logic [BIT_W-1:0]      bit_reg;
    logic                  ovf_reg, special_reg;

    logic [SIZE_W:0]       diff;
    logic                  k_gt_n, k_edge;
    logic [SIZE_W-1:0]     m_load;
    logic [VALUE_BITS-1:0] mul_a;
    logic [PROD_W-1:0]     product;
    logic                  prod_ovf;
    logic [VALUE_BITS:0]   shifted, trial;
    logic                  q_bit;

    always_comb
    begin
        diff    = {1'b0, set_size} - {1'b0, subset_size};
        k_gt_n  = diff[SIZE_W];
        k_edge  = (subset_size == '0) || (subset_size == set_size);
        m_load  = (subset_size > diff[SIZE_W-1:0]) ? subset_size : diff[SIZE_W-1:0];

        mul_a    = (ctrl.op == OP_MUL_DEN) ? den_reg : acc_reg;
        product  = PROD_W'(mul_a) * PROD_W'(cnt_reg);
        prod_ovf = |product[PROD_W-1:VALUE_BITS];

        shifted = {rem_reg, quo_reg[VALUE_BITS-1]};
        trial   = shifted - {1'b0, den_reg};
        q_bit   = ~trial[VALUE_BITS];
    end

    // Datapath registers carry no control meaning outside a request, so
    // they take no reset.
    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            OP_LOAD:
            begin
                if (ctrl.req_taken)
                begin
                    m_reg       <= m_load;
                    d_reg       <= set_size - m_load;
                    cnt_reg     <= set_size;
                    acc_reg     <= VALUE_BITS'(1);
                    ovf_reg     <= 1'b0;
                    special_reg <= k_gt_n || k_edge;
                    quo_reg     <= VALUE_BITS'(!k_gt_n && k_edge);
                end
            end
            OP_MUL_NUM:
            begin
                if (prod_ovf)
                    ovf_reg <= 1'b1;
                else
                    acc_reg <= product[VALUE_BITS-1:0];
                cnt_reg <= cnt_reg - SIZE_W'(1);
            end
            OP_INIT_DEN:
            begin
                den_reg <= VALUE_BITS'(1);
                cnt_reg <= d_reg;
            end
            OP_MUL_DEN:
            begin
                if (prod_ovf)
                    ovf_reg <= 1'b1;
                else
                    den_reg <= product[VALUE_BITS-1:0];
                cnt_reg <= cnt_reg - SIZE_W'(1);
            end
            OP_INIT_DIV:
            begin
                rem_reg <= '0;
                quo_reg <= acc_reg;
                bit_reg <= BIT_W'(VALUE_BITS - 1);
            end
            OP_DIV_STEP:
            begin
                rem_reg <= q_bit ? trial[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
                quo_reg <= {quo_reg[VALUE_BITS-2:0], q_bit};
                bit_reg <= bit_reg - BIT_W'(1);
            end
            OP_SET_OVF:
            begin
                quo_reg <= '0;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.special   = special_reg;
    assign stat.num_done  = (cnt_reg <= m_reg) || ovf_reg;
    assign stat.den_done  = (cnt_reg <= SIZE_W'(1)) || ovf_reg;
    assign stat.ovf       = ovf_reg;
    assign stat.bits_left = (bit_reg != '0);
    assign quotient       = quo_reg;
    assign overflow       = ovf_reg;

    // A division only starts with a non-zero divisor.
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == OP_DIV_STEP |-> den_reg != '0)
        else $error("divider started with a zero divisor");

    // Once overflow is seen the multiplier loops stop at their next test.
    a_ovf_stops: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg && ctrl.op != OP_LOAD |-> stat.num_done && stat.den_done)
        else $error("product loop continues after overflow");

    // The remainder of a restoring divider stays below the divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $past(ctrl.op) == OP_DIV_STEP |-> rem_reg < den_reg)
        else $error("division remainder out of range");

endmodule

[sv/binomial_coefficient_core.sv]
// ============================================================================
// binomial_coefficient_core: n choose k by a microcoded sequencer
// A step counter walks a short read-only microprogram whose control words
// drive a shared multiplier and a bit-serial divider.
// ============================================================================
//
//  channel | dir | fields                       | notes
//  --------+-----+------------------------------+------------------------------
//  req     | in  | set_size, subset_size        | one request, one result
//  rsp     | out | combinations, overflowed     | 0 with flag set on overflow
//
//  A request whose subset is empty, full or larger than the set skips the
//  arithmetic and goes straight to the wait step. Otherwise the numerator
//  takes the factors n down to m+1 and the denominator n-m down to 2, with m
//  the larger of k and n-k, each factor in a test step and a multiply step,
//  and the divider then retires one quotient bit per step.
//  Reset is asynchronous and active low; it returns the step counter to idle
//  and empties the result register. A result waits in its register while the
//  sink stalls; the sequencer holds at its wait step until that register is
//  free, and the next request is taken once the result has been written.
//
module binomial_coefficient_core #(
    parameter int VALUE_BITS = 63
) (
    input  logic      clk,
    input  logic      rst_n,
    bnc_req_if.sink   req,
    bnc_rsp_if.source rsp
);
    import bnc_pkg::*;

    // Step counter and the control word that it selects.
    step_t     upc_reg, upc_next;
    ucode_t    word;
    logic      jump;

    // Result register, parted from the sequencer so that the sink can stall.
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] comb_reg;
    logic                  ovf_out_reg;

    bnc_ctrl_t             ctrl;
    bnc_stat_t             stat;
    logic [VALUE_BITS-1:0] quotient;
    logic                  overflow;
    logic                  out_busy;

    assign word     = ucode_rom(upc_reg);
    assign out_busy = out_valid_reg && !rsp.ready;

    // Requests are taken only at the idle step of the microprogram.
    assign req.ready     = (upc_reg == STEP_IDLE);
    assign ctrl.op       = word.op;
    assign ctrl.req_taken = req.valid && req.ready;

    bnc_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .set_size    (req.set_size),
        .subset_size (req.subset_size),
        .stat        (stat),
        .quotient    (quotient),
        .overflow    (overflow)
    );

    // Evaluate the jump condition of the current control word. The wait step
    // holds in place while the result register is still occupied.
    always_comb
    begin
        unique case (word.cond)
            C_NEVER:     jump = 1'b0;
            C_ALWAYS:    jump = 1'b1;
            C_NO_REQ:    jump = !req.valid;
            C_SPECIAL:   jump = stat.special;
            C_NUM_DONE:  jump = stat.num_done;
            C_DEN_DONE:  jump = stat.den_done;
            C_OVF:       jump = stat.ovf;
            C_BITS_LEFT: jump = stat.bits_left;
            default:     jump = 1'b0;
        endcase

        if (upc_reg == STEP_WAIT_OUT && out_busy)
            upc_next = upc_reg;
        else if (jump)
            upc_next = word.target;
        else
            upc_next = upc_reg + step_t'(1);

        if (word.op == OP_PUBLISH)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= STEP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The payload is loaded only when the microprogram publishes a result.
    always_ff @(posedge clk)
    begin
        if (word.op == OP_PUBLISH)
        begin
            comb_reg    <= quotient;
            ovf_out_reg <= overflow;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.combinations = COMB_W'(comb_reg);
    assign rsp.overflowed   = ovf_out_reg;

    // An overflowed result always carries a zero count.
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.overflowed |-> rsp.combinations == '0)
        else $error("overflow reported with a non-zero count");

    // A result is never written over one that the sink has not yet taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        word.op == OP_PUBLISH |-> !out_busy)
        else $error("result register overwritten while occupied");

    // A taken request always moves the sequencer to classification.
    a_req_start: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> upc_reg == STEP_CLASSIFY)
        else $error("sequencer did not start after a request");

    // The count never exceeds the arithmetic width.
    a_width: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.combinations >> VALUE_BITS) == '0)
        else $error("count wider than the arithmetic");

endmodule
